@@ src/assert_macros.svh @@
// Assertion macros shared by the allocator RTL.
// Depends on nothing; the checks compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_CLK_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst, prop, msg)
`define ASSERT_CLK_NR(lbl, clk, prop, msg)
`endif
`endif

@@ src/scfla_pkg.sv @@
// Shared constants, request and status codes, and the size-to-class table
// of the size class free list allocator. No dependencies.
package scfla_pkg;

  localparam int NUM_CLASSES_DEF   = 16;
  localparam int CLASS_SPACING_DEF = 8;
  localparam int POOL_BLOCKS_DEF   = 1024;

  localparam int SIZE_W = 8;
  localparam int BLK_W  = 10;
  localparam int CNT_W  = 11;
  localparam int POOL_CMP_W = 17;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_FREE  = 2'd1;
  localparam logic [1:0] REQ_GROW  = 2'd2;
  localparam logic [1:0] REQ_CLEAR = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  typedef logic [7:0] cls_tab_t [256];

  // Builds the class of every byte size by counting, so no division is needed.
  function automatic cls_tab_t class_table(int spacing);
    cls_tab_t t;
    int c;
    int r;
    c = 0;
    r = 0;
    t[0] = 8'd0;
    for (int s = 1; s < 256; s++) begin
      t[s] = 8'(c);
      r++;
      if (r == spacing) begin
        r = 0;
        c++;
      end
    end
    return t;
  endfunction

endpackage

@@ src/scfla_class_mem.sv @@
// Per-class state memory: list head and counters, one entry per size class.
// Valid bits make an unwritten or cleared entry read as all zero. Uses scfla_pkg.
module scfla_class_mem #(
  parameter int  Depth = scfla_pkg::NUM_CLASSES_DEF,
  parameter int  AddrW = (Depth > 1) ? $clog2(Depth) : 1,
  parameter type entry_t = logic
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             clr,
  input  logic             rd_en,
  input  logic [AddrW-1:0] rd_addr,
  output entry_t           rd_data,
  input  logic             wr_en,
  input  logic [AddrW-1:0] wr_addr,
  input  entry_t           wr_data
);
  import scfla_pkg::*;

  entry_t           mem [Depth];
  logic [Depth-1:0] valid;
  entry_t           rd_q;
  logic             rd_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else if (rd_en) begin
      rd_valid <= valid[rd_addr];
    end
  end

  assign rd_data = rd_valid ? rd_q : entry_t'('0);

endmodule

@@ src/scfla_link_mem.sv @@
// Next-link memory over the block pool, one link entry per block.
// Synchronous write, registered read. Uses scfla_pkg for defaults.
module scfla_link_mem #(
  parameter int  Depth = scfla_pkg::POOL_BLOCKS_DEF,
  parameter int  AddrW = $clog2(Depth),
  parameter type entry_t = logic
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AddrW-1:0] rd_addr,
  output entry_t           rd_data,
  input  logic             wr_en,
  input  logic [AddrW-1:0] wr_addr,
  input  entry_t           wr_data
);
  import scfla_pkg::*;

  entry_t mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ src/size_class_free_list_allocator.sv @@
// Segregated free list allocator: one LIFO free list per size class, linked
// through a next-link memory. Instantiates scfla_class_mem and scfla_link_mem.
//
// A request is taken when start is high and busy is low; its one result shows
// on the result ports for a single cycle with done high, and the receiver
// cannot stall it, so it must be captured in that cycle. Clear and bad-size
// requests finish without leaving the idle state. Free does a class memory
// read, then a write back; alloc does a class memory read, then a link memory
// read of the head, then a write back; an alloc from an empty list ends after
// the class memory read, and grow follows the read with a walk that writes one
// link entry per cycle. A grow that fails or has a count of zero ends after
// the class memory read. Clear needs no pass because the class memory keeps a
// valid bit per entry; there is no clearing pass after reset, and the block
// takes requests right away.
`include "assert_macros.svh"
module size_class_free_list_allocator #(
  parameter int NUM_CLASSES   = scfla_pkg::NUM_CLASSES_DEF,
  parameter int CLASS_SPACING = scfla_pkg::CLASS_SPACING_DEF,
  parameter int POOL_BLOCKS   = scfla_pkg::POOL_BLOCKS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   req_type,
  input  logic [scfla_pkg::SIZE_W-1:0] size_bytes,
  input  logic [scfla_pkg::BLK_W-1:0]  block_index,
  input  logic [scfla_pkg::CNT_W-1:0]  block_count,
  output logic                         done,
  output logic [scfla_pkg::BLK_W-1:0]  granted_block,
  output logic [1:0]                   status,
  output logic [scfla_pkg::CNT_W-1:0]  blocks_in_use,
  output logic [scfla_pkg::CNT_W-1:0]  peak_in_use,
  output logic [scfla_pkg::CNT_W-1:0]  blocks_owned
);
  import scfla_pkg::*;

  localparam int CLS_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int IDX_W = $clog2(POOL_BLOCKS);
  localparam logic [POOL_CMP_W-1:0] POOL_L = POOL_CMP_W'(POOL_BLOCKS);
  localparam logic [7:0] NCLS_L = 8'(NUM_CLASSES);
  localparam cls_tab_t CLS_TAB = class_table(CLASS_SPACING);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CLS  = 2'd1;
  localparam logic [1:0] S_LINK = 2'd2;
  localparam logic [1:0] S_GROW = 2'd3;

  typedef struct packed {
    logic             head_valid;
    logic [IDX_W-1:0] head;
    logic [CNT_W-1:0] in_use;
    logic [CNT_W-1:0] peak;
    logic [CNT_W-1:0] owned;
  } class_entry_t;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
  } link_entry_t;

  logic [1:0]        state;
  logic [1:0]        req_q;
  logic [BLK_W-1:0]  blk_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [SIZE_W-1:0] size_q;
  class_entry_t      ent;
  logic [IDX_W-1:0]  cur;
  logic [CNT_W-1:0]  rem;

  logic         accept;
  logic         clr_req;
  logic [7:0]   cls_raw;
  logic         size_bad;
  logic         cls_rd_en;
  class_entry_t cls_rd;
  logic         cls_we;
  class_entry_t cls_wd;
  logic         link_rd_en;
  link_entry_t  link_rd;
  logic         link_we;
  logic [IDX_W-1:0] link_wa;
  link_entry_t  link_wd;

  logic             free_over;
  logic             grow_over;
  logic [CNT_W:0]   own_sum;
  logic [CNT_W-1:0] own_sat;
  logic [CNT_W-1:0] use_inc;
  logic [CNT_W-1:0] use_dec;

  logic             fin;
  logic [1:0]       res_status;
  logic [BLK_W-1:0] res_granted;
  logic [CNT_W-1:0] res_in_use;
  logic [CNT_W-1:0] res_peak;
  logic [CNT_W-1:0] res_owned;

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign clr_req  = accept && (req_type == REQ_CLEAR);
  assign cls_raw  = CLS_TAB[size_bytes];
  assign size_bad = (size_bytes == '0) || (cls_raw >= NCLS_L);
  assign cls_rd_en = accept && (req_type != REQ_CLEAR) && !size_bad;

  assign free_over = (POOL_CMP_W'(blk_q) >= POOL_L);
  assign grow_over = ((POOL_CMP_W'(blk_q) + POOL_CMP_W'(cnt_q)) > POOL_L);
  assign own_sum   = {1'b0, ent.owned} + {1'b0, cnt_q};
  assign own_sat   = own_sum[CNT_W] ? CNT_MAX : own_sum[CNT_W-1:0];
  assign use_inc   = (ent.in_use == CNT_MAX) ? ent.in_use : ent.in_use + CNT_W'(1);
  assign use_dec   = (cls_rd.in_use == '0) ? cls_rd.in_use : cls_rd.in_use - CNT_W'(1);

  assign link_rd_en = (state == S_CLS) && (req_q == REQ_ALLOC) && cls_rd.head_valid;

  always_comb begin
    cls_we      = 1'b0;
    cls_wd      = cls_rd;
    link_we     = 1'b0;
    link_wa     = cur;
    link_wd     = '{valid: ent.head_valid, idx: ent.head};
    fin         = 1'b0;
    res_status  = ST_OK;
    res_granted = '0;
    res_in_use  = cls_rd.in_use;
    res_peak    = cls_rd.peak;
    res_owned   = cls_rd.owned;
    case (state)
      S_IDLE: begin
        res_in_use = '0;
        res_peak   = '0;
        res_owned  = '0;
        if (clr_req) begin
          fin = 1'b1;
        end else if (accept && size_bad) begin
          fin        = 1'b1;
          res_status = ST_BAD;
        end
      end
      S_CLS: begin
        case (req_q)
          REQ_ALLOC: begin
            if (!cls_rd.head_valid) begin
              fin        = 1'b1;
              res_status = ST_EMPTY;
            end
          end
          REQ_FREE: begin
            fin = 1'b1;
            if (free_over) begin
              res_status = ST_RANGE;
            end else begin
              link_we   = 1'b1;
              link_wa   = IDX_W'(blk_q);
              link_wd   = '{valid: cls_rd.head_valid, idx: cls_rd.head};
              cls_we    = 1'b1;
              cls_wd.head_valid = 1'b1;
              cls_wd.head       = IDX_W'(blk_q);
              cls_wd.in_use     = use_dec;
              res_in_use = use_dec;
            end
          end
          default: begin
            // Grow: a bad range or an empty run finishes here.
            if (grow_over) begin
              fin        = 1'b1;
              res_status = ST_RANGE;
            end else if (cnt_q == '0) begin
              fin = 1'b1;
            end
          end
        endcase
      end
      S_LINK: begin
        cls_we = 1'b1;
        cls_wd = '{head_valid: link_rd.valid, head: link_rd.idx, in_use: use_inc,
                   peak: (use_inc > ent.peak) ? use_inc : ent.peak, owned: ent.owned};
        fin         = 1'b1;
        res_granted = BLK_W'(ent.head);
        res_in_use  = cls_wd.in_use;
        res_peak    = cls_wd.peak;
        res_owned   = cls_wd.owned;
      end
      default: begin
        // Grow walk: push one block per cycle, the last one becomes the head.
        link_we    = 1'b1;
        res_in_use = ent.in_use;
        res_peak   = ent.peak;
        res_owned  = own_sat;
        if (rem == CNT_W'(1)) begin
          cls_we = 1'b1;
          cls_wd = '{head_valid: 1'b1, head: cur, in_use: ent.in_use,
                     peak: ent.peak, owned: own_sat};
          fin    = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (cls_rd_en) begin
            state <= S_CLS;
          end
        end
        S_CLS: begin
          if (link_rd_en) begin
            state <= S_LINK;
          end else if ((req_q == REQ_GROW) && !grow_over && (cnt_q != '0)) begin
            state <= S_GROW;
          end else begin
            state <= S_IDLE;
          end
        end
        S_LINK: begin
          state <= S_IDLE;
        end
        default: begin
          if (fin) begin
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

  // The class write address comes from the size latched at the transfer.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q  <= req_type;
      blk_q  <= block_index;
      cnt_q  <= block_count;
      size_q <= size_bytes;
    end
    if (state == S_CLS) begin
      ent <= cls_rd;
      cur <= IDX_W'(blk_q);
      rem <= cnt_q;
    end else if (state == S_GROW) begin
      ent.head_valid <= 1'b1;
      ent.head       <= cur;
      cur            <= cur + IDX_W'(1);
      rem            <= rem - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      granted_block <= res_granted;
      status        <= res_status;
      blocks_in_use <= res_in_use;
      peak_in_use   <= res_peak;
      blocks_owned  <= res_owned;
    end
  end

  scfla_class_mem #(
    .Depth   (NUM_CLASSES),
    .AddrW   (CLS_W),
    .entry_t (class_entry_t)
  ) u_class_mem (
    .clk     (clk),
    .rst     (rst),
    .clr     (clr_req),
    .rd_en   (cls_rd_en),
    .rd_addr (CLS_W'(cls_raw)),
    .rd_data (cls_rd),
    .wr_en   (cls_we),
    .wr_addr (CLS_W'(CLS_TAB[size_q])),
    .wr_data (cls_wd)
  );

  scfla_link_mem #(
    .Depth   (POOL_BLOCKS),
    .AddrW   (IDX_W),
    .entry_t (link_entry_t)
  ) u_link_mem (
    .clk     (clk),
    .rd_en   (link_rd_en),
    .rd_addr (cls_rd.head),
    .rd_data (link_rd),
    .wr_en   (link_we),
    .wr_addr (link_wa),
    .wr_data (link_wd)
  );

  `ASSERT_CLK(a_done_idle, clk, rst, done |-> !busy, "result shown while busy")
  `ASSERT_CLK(a_grant_ok, clk, rst, done && (granted_block != '0) |-> status == ST_OK, "bad grant")
  `ASSERT_CLK(a_peak_ge_use, clk, rst, done |-> (peak_in_use >= blocks_in_use), "peak below use")
  `ASSERT_CLK(a_clear_result, clk, rst, clr_req |=> done && (blocks_owned == '0), "no clear result")

endmodule

@@ sim/tb_size_class_free_list_allocator.sv @@
// Self-checking testbench for size_class_free_list_allocator.
// Depends on scfla_pkg and the allocator RTL. Each result is checked against
// a behavioral copy of the per-class free lists kept in this file.
`timescale 1ns / 1ps

module tb_size_class_free_list_allocator;
  import scfla_pkg::*;

  localparam int NCLS    = NUM_CLASSES_DEF;
  localparam int SPACING = CLASS_SPACING_DEF;
  localparam int POOL    = POOL_BLOCKS_DEF;
  localparam int SAT     = int'(CNT_MAX);

  typedef struct packed {
    logic [BLK_W-1:0] granted;
    logic [1:0]       status;
    logic [CNT_W-1:0] in_use;
    logic [CNT_W-1:0] peak;
    logic [CNT_W-1:0] owned;
  } alloc_result_t;

  typedef struct {
    int               cls;
    logic [BLK_W-1:0] blk;
  } held_block_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic [1:0]        req_type = REQ_CLEAR;
  logic [SIZE_W-1:0] size_bytes = '0;
  logic [BLK_W-1:0]  block_index = '0;
  logic [CNT_W-1:0]  block_count = '0;
  logic              busy;
  logic              done;
  logic [BLK_W-1:0]  granted_block;
  logic [1:0]        status;
  logic [CNT_W-1:0]  blocks_in_use;
  logic [CNT_W-1:0]  peak_in_use;
  logic [CNT_W-1:0]  blocks_owned;

  // Predicted allocator state.
  logic [BLK_W-1:0] class_head [NCLS];
  bit               class_head_ok [NCLS];
  logic [BLK_W-1:0] link_next [POOL];
  bit               link_ok [POOL];
  int               in_use_cnt [NCLS];
  int               peak_cnt [NCLS];
  int               owned_cnt [NCLS];

  alloc_result_t pending_results[$];
  held_block_t   held_blocks[$];
  int            mismatches = 0;
  int            idle_pct = 0;

  size_class_free_list_allocator u_top (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .req_type      (req_type),
    .size_bytes    (size_bytes),
    .block_index   (block_index),
    .block_count   (block_count),
    .done          (done),
    .granted_block (granted_block),
    .status        (status),
    .blocks_in_use (blocks_in_use),
    .peak_in_use   (peak_in_use),
    .blocks_owned  (blocks_owned)
  );

  always #4 clk = ~clk;

  initial begin
    #200_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    for (int c = 0; c < NCLS; c++) begin
      class_head_ok[c] = 1'b0;
      in_use_cnt[c] = 0;
      peak_cnt[c] = 0;
      owned_cnt[c] = 0;
    end
  end

  function automatic void push_free_block(int cls, int blk);
    link_next[blk] = class_head[cls];
    link_ok[blk] = class_head_ok[cls];
    class_head[cls] = BLK_W'(blk);
    class_head_ok[cls] = 1'b1;
  endfunction

  // Applies one request to the predicted lists and returns the result it causes.
  function automatic alloc_result_t predict_response(logic [1:0] rq, logic [SIZE_W-1:0] sz,
                                                     logic [BLK_W-1:0] blk,
                                                     logic [CNT_W-1:0] cnt);
    alloc_result_t r;
    int cls;
    int h;
    r = '0;
    if (rq == REQ_CLEAR) begin
      for (int c = 0; c < NCLS; c++) begin
        class_head_ok[c] = 1'b0;
        in_use_cnt[c] = 0;
        peak_cnt[c] = 0;
        owned_cnt[c] = 0;
      end
      return r;
    end
    if (sz == 0 || (int'(sz) - 1) / SPACING >= NCLS) begin
      r.status = ST_BAD;
      return r;
    end
    cls = (int'(sz) - 1) / SPACING;
    case (rq)
      REQ_ALLOC: begin
        if (!class_head_ok[cls]) begin
          r.status = ST_EMPTY;
        end else begin
          h = int'(class_head[cls]);
          r.granted = BLK_W'(h);
          class_head[cls] = link_next[h];
          class_head_ok[cls] = link_ok[h];
          if (in_use_cnt[cls] < SAT) in_use_cnt[cls]++;
          if (in_use_cnt[cls] > peak_cnt[cls]) peak_cnt[cls] = in_use_cnt[cls];
        end
      end
      REQ_FREE: begin
        if (int'(blk) >= POOL) begin
          r.status = ST_RANGE;
        end else begin
          if (in_use_cnt[cls] > 0) in_use_cnt[cls]--;
          push_free_block(cls, int'(blk));
        end
      end
      default: begin
        if (int'(blk) + int'(cnt) > POOL) begin
          r.status = ST_RANGE;
        end else begin
          for (int k = 0; k < int'(cnt); k++) push_free_block(cls, int'(blk) + k);
          owned_cnt[cls] += int'(cnt);
          if (owned_cnt[cls] > SAT) owned_cnt[cls] = SAT;
        end
      end
    endcase
    r.in_use = CNT_W'(in_use_cnt[cls]);
    r.peak = CNT_W'(peak_cnt[cls]);
    r.owned = CNT_W'(owned_cnt[cls]);
    return r;
  endfunction

  function automatic logic [SIZE_W-1:0] size_for_class(int cls);
    return SIZE_W'(cls * SPACING + 1 + $urandom_range(SPACING - 1));
  endfunction

  // Drives one request, holds it until the transfer, and queues its prediction.
  // Start is left high so back-to-back requests need no second assignment.
  task automatic issue_request(input logic [1:0] rq, input logic [SIZE_W-1:0] sz,
                               input logic [BLK_W-1:0] blk, input logic [CNT_W-1:0] cnt,
                               output alloc_result_t pred);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    start <= 1'b1;
    req_type <= rq;
    size_bytes <= sz;
    block_index <= blk;
    block_count <= cnt;
    do @(posedge clk); while (busy !== 1'b0);
    pred = predict_response(rq, sz, blk, cnt);
    pending_results.insert(pending_results.size(), pred);
  endtask

  always @(posedge clk) begin : check_results
    alloc_result_t seen;
    alloc_result_t want;
    if (!rst && done === 1'b1) begin
      seen = '{granted_block, status, blocks_in_use, peak_in_use, blocks_owned};
      if (pending_results.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: granted=%0d status=%0d in_use=%0d peak=%0d owned=%0d",
                   seen.granted, seen.status, seen.in_use, seen.peak, seen.owned);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (seen !== want) begin
          if (mismatches < 10) begin
            $display("mismatch at %0t: expected granted=%0d status=%0d in_use=%0d",
                     $realtime, want.granted, want.status, want.in_use);
            $display("  expected peak=%0d owned=%0d", want.peak, want.owned);
            $display("  actual granted=%0d status=%0d in_use=%0d peak=%0d owned=%0d",
                     seen.granted, seen.status, seen.in_use, seen.peak, seen.owned);
          end
          mismatches++;
        end
      end
    end
  end

  task automatic test_directed_corners();
    alloc_result_t p;
    issue_request(REQ_ALLOC, 8'd1, 10'd0, 11'd0, p);        // empty list
    issue_request(REQ_ALLOC, 8'd0, 10'd5, 11'd3, p);        // size zero
    issue_request(REQ_GROW, 8'd129, 10'd0, 11'd4, p);       // first class past the end
    issue_request(REQ_FREE, 8'd255, 10'd1023, 11'd2047, p);
    issue_request(REQ_GROW, 8'd8, 10'd1020, 11'd4, p);      // ends exactly at the pool top
    issue_request(REQ_GROW, 8'd8, 10'd1023, 11'd2, p);      // runs one past the pool
    issue_request(REQ_GROW, 8'd8, 10'd0, 11'd2047, p);
    issue_request(REQ_GROW, 8'd8, 10'd512, 11'd0, p);       // empty run succeeds
    issue_request(REQ_ALLOC, 8'd1, 10'd0, 11'd0, p);        // last block pushed comes first
    issue_request(REQ_ALLOC, 8'd5, 10'd0, 11'd0, p);
    issue_request(REQ_FREE, 8'd8, 10'd1023, 11'd0, p);
    issue_request(REQ_FREE, 8'd9, 10'd0, 11'd0, p);         // in-use already zero
    issue_request(REQ_ALLOC, 8'd9, 10'd0, 11'd0, p);
    issue_request(REQ_ALLOC, 8'd128, 10'd0, 11'd0, p);
    issue_request(REQ_GROW, 8'd128, 10'd0, 11'd1024, p);    // whole pool
    issue_request(REQ_GROW, 8'd121, 10'd0, 11'd1024, p);    // owned count saturates
    issue_request(REQ_ALLOC, 8'd121, 10'd0, 11'd0, p);
    issue_request(REQ_CLEAR, 8'd255, 10'd1023, 11'd2047, p);
    issue_request(REQ_ALLOC, 8'd1, 10'd0, 11'd0, p);
    issue_request(REQ_ALLOC, 8'd128, 10'd0, 11'd0, p);
    issue_request(REQ_FREE, 8'd16, 10'd341, 11'd0, p);
    issue_request(REQ_ALLOC, 8'd16, 10'd0, 11'd0, p);
  endtask

  // Freeing the same block twice links it to itself, so allocs never run dry
  // and the in-use and peak counts climb past the number of frees.
  task automatic test_self_linked_block();
    alloc_result_t p;
    issue_request(REQ_CLEAR, 8'd0, 10'd0, 11'd0, p);
    issue_request(REQ_FREE, 8'd41, 10'd77, 11'd0, p);
    issue_request(REQ_FREE, 8'd48, 10'd77, 11'd0, p);
    for (int i = 0; i < 16; i++) issue_request(REQ_ALLOC, 8'd44, 10'd0, 11'd0, p);
    issue_request(REQ_FREE, 8'd41, 10'd77, 11'd0, p);
    issue_request(REQ_CLEAR, 8'd0, 10'd0, 11'd0, p);
  endtask

  task automatic test_random_traffic(input int n_items);
    alloc_result_t p;
    held_block_t hb;
    int sel;
    int cls;
    int idx;
    for (int i = 0; i < n_items; i++) begin
      sel = $urandom_range(99);
      cls = ($urandom_range(1) == 1) ? $urandom_range(NCLS - 1) : $urandom_range(3);
      if (sel < 5) begin
        issue_request(2'($urandom_range(2)),
                      ($urandom_range(1) == 1) ? 8'd0 : SIZE_W'($urandom_range(129, 255)),
                      BLK_W'($urandom), CNT_W'($urandom), p);
      end else if (sel < 8) begin
        issue_request(REQ_CLEAR, SIZE_W'($urandom), BLK_W'($urandom), CNT_W'($urandom), p);
      end else if (sel < 45) begin
        issue_request(REQ_ALLOC, size_for_class(cls), BLK_W'($urandom), CNT_W'($urandom), p);
        if (p.status == ST_OK) begin
          hb.cls = cls;
          hb.blk = p.granted;
          held_blocks.insert(held_blocks.size(), hb);
        end
      end else if (sel < 70) begin
        if (held_blocks.size() > 0 && $urandom_range(99) < 80) begin
          idx = $urandom_range(held_blocks.size() - 1);
          hb = held_blocks[idx];
          held_blocks.delete(idx);
        end else begin
          hb.cls = cls;
          hb.blk = BLK_W'($urandom);
        end
        issue_request(REQ_FREE, size_for_class(hb.cls), hb.blk, CNT_W'($urandom), p);
      end else if (sel < 97) begin
        issue_request(REQ_GROW, size_for_class(cls), BLK_W'($urandom),
                      CNT_W'($urandom_range(1, 8)), p);
      end else begin
        issue_request(REQ_GROW, size_for_class(cls), BLK_W'($urandom), CNT_W'($urandom), p);
      end
    end
  endtask

  initial begin
    int guard;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_corners();
    test_self_linked_block();
    // The receiver cannot stall results, so only the sender idles.
    idle_pct = 0;
    test_random_traffic(135);
    idle_pct = 61;
    test_random_traffic(135);
    idle_pct = 22;
    test_random_traffic(135);
    start <= 1'b0;
    guard = 0;
    while (pending_results.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
